// ===== src/ncpl_pkg.sv =====
// Shared types and constants for the nearest-claimant point lock table.
// Depends on nothing; used by ncpl_slot_eval and the core top level.
`default_nettype none

package ncpl_pkg;

  // Field widths of the stream payloads
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned LOCK_ID_W = 16;
  localparam int unsigned DIST_W    = 24;
  localparam int unsigned RADIUS_W  = 16;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned MULT_W    = 2;

  // Distance code for a claim that has not reported yet
  localparam logic [DIST_W-1:0] DIST_UNSET = {DIST_W{1'b1}};

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_KEY_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ID_ABSENT  = 2'd3;

  // Speed multiplier codes (two bit signed)
  localparam logic [MULT_W-1:0] MULT_BACK = 2'b11;
  localparam logic [MULT_W-1:0] MULT_WAIT = 2'b00;
  localparam logic [MULT_W-1:0] MULT_GO   = 2'b01;

  // Running state of one scan over the table
  typedef struct packed {
    logic              key_seen;
    logic              id_seen;
    logic              have_best;
    logic              best_match;
    logic [DIST_W-1:0] best_dist;
  } acc_t;

  // Per-slot control from the slot evaluator
  typedef struct packed {
    logic hit;
    logic wr_en;
  } eval_flags_t;

endpackage

`default_nettype wire

// ===== src/ncpl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ncpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ncpl_slot_eval.sv =====
// Read-modify-write evaluation of one table slot during a scan.
// Depends on ncpl_pkg for codes and the scan accumulator type.
`default_nettype none

module ncpl_slot_eval #(
  parameter int unsigned ID_BITS = 16
) (
  input  wire logic [ncpl_pkg::FUNC_W-1:0]    func,
  input  wire logic [ncpl_pkg::KEY_W-1:0]     key,
  input  wire logic [ncpl_pkg::LOCK_ID_W-1:0] lock_id,
  input  wire logic [ncpl_pkg::DIST_W-1:0]    distance,
  input  wire logic [ID_BITS-1:0]             next_id,
  input  wire logic                           ent_valid,
  input  wire logic [ncpl_pkg::KEY_W-1:0]     ent_key,
  input  wire logic [ID_BITS-1:0]             ent_id,
  input  wire logic [ncpl_pkg::DIST_W-1:0]    ent_dist,
  input  wire ncpl_pkg::acc_t                 acc_in,
  output ncpl_pkg::acc_t                      acc_out,
  output ncpl_pkg::eval_flags_t               flags,
  output logic                                wr_valid,
  output logic      [ncpl_pkg::KEY_W-1:0]     wr_key,
  output logic      [ID_BITS-1:0]             wr_id,
  output logic      [ncpl_pkg::DIST_W-1:0]    wr_dist
);

  localparam int unsigned CMP_W =
    (ID_BITS > ncpl_pkg::LOCK_ID_W) ? ID_BITS : ncpl_pkg::LOCK_ID_W;

  logic                        key_hit;
  logic                        id_hit;
  logic [ncpl_pkg::DIST_W-1:0] eff_dist;

  assign key_hit = ent_valid && (ent_key == key);
  assign id_hit  = (CMP_W'(ent_id) == CMP_W'(lock_id));

  // Distance of this slot after a query has updated it
  assign eff_dist = (key_hit && id_hit) ? distance : ent_dist;

  // Evaluate the slot for the current operation
  always_comb begin
    acc_out  = acc_in;
    flags    = '0;
    wr_valid = ent_valid;
    wr_key   = ent_key;
    wr_id    = ent_id;
    wr_dist  = ent_dist;
    unique case (func)
      ncpl_pkg::FUNC_ACQUIRE: begin
        // Claim the first free slot
        if (!ent_valid) begin
          flags.hit   = 1'b1;
          flags.wr_en = 1'b1;
          wr_valid    = 1'b1;
          wr_key      = key;
          wr_id       = next_id;
          wr_dist     = ncpl_pkg::DIST_UNSET;
        end
      end
      ncpl_pkg::FUNC_RELEASE: begin
        // Drop the first claim matching key and id
        if (key_hit) begin
          acc_out.key_seen = 1'b1;
          if (id_hit) begin
            flags.hit   = 1'b1;
            flags.wr_en = 1'b1;
            wr_valid    = 1'b0;
          end
        end
      end
      ncpl_pkg::FUNC_QUERY: begin
        // Store the caller distance and track the nearest set distance
        if (key_hit) begin
          acc_out.key_seen = 1'b1;
          if (id_hit) begin
            acc_out.id_seen = 1'b1;
            flags.wr_en     = 1'b1;
            wr_dist         = distance;
          end
          if (eff_dist < acc_in.best_dist) begin
            acc_out.have_best  = 1'b1;
            acc_out.best_dist  = eff_dist;
            acc_out.best_match = id_hit;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/nearest_claimant_point_lock_table_core.sv =====
// Top level of the nearest-claimant point lock table: stream ports, scan
// sequencer, result register. Depends on ncpl_pkg, ncpl_ram, ncpl_slot_eval.
//
// Use: one operation per input beat (acquire, release, query), selected by
// in_tuser. Each beat yields exactly one result beat on the out_ channel.
// All claims live in one synchronous RAM of TABLE_ENTRIES words with
// registered read data. Every operation walks the slots from slot 0 with one
// read per cycle and writes the modified slot back in the cycle its data
// returns; acquire and release stop at the first slot they hit.
// A full scan gives the longest wait from input beat to result beat;
// acquire and release finish sooner when they hit early. A new beat is
// taken once the previous result has moved into the output register, so
// a new item is not taken while the last is still being scanned; the
// single RAM read port serves one scan at a time. Reads and write-backs
// of one scan always target different slots, and scans never overlap, so
// no forwarding is used. After reset the block clears the valid bit of
// every slot, one per cycle; in_tready stays low until that pass ends.
// A stalled receiver holds the result in the output register; one further
// item may be scanned meanwhile and then waits for the register to free up.
`default_nettype none

module nearest_claimant_point_lock_table_core #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned ID_BITS       = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] key, [47:32] lock_id, [71:48] distance, [87:72] agent_radius
  input  wire logic [87:0] in_tdata,
  // [1:0] func
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] new_id, [16] granted, [18:17] multiplier, [20:19] status
  output logic [23:0]      out_tdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned ENT_W =
    1 + ncpl_pkg::KEY_W + ID_BITS + ncpl_pkg::DIST_W;
  localparam int unsigned ID_LSB  = ncpl_pkg::DIST_W;
  localparam int unsigned KEY_LSB = ncpl_pkg::DIST_W + ID_BITS;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  // Control registers
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] proc_idx_r, proc_idx_nxt;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  // Payload registers
  logic [ncpl_pkg::FUNC_W-1:0]    func_r;
  logic [ncpl_pkg::KEY_W-1:0]     key_r;
  logic [ncpl_pkg::LOCK_ID_W-1:0] lock_id_r;
  logic [ncpl_pkg::DIST_W-1:0]    dist_r;
  logic [ncpl_pkg::RADIUS_W-1:0]  radius_r;
  ncpl_pkg::acc_t                 acc_r, acc_nxt;
  logic [23:0]                    res_r, res_nxt;
  logic [23:0]                    out_tdata_r, out_tdata_nxt;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [ENT_W-1:0] ram_rdata;

  // Evaluator signals
  ncpl_pkg::acc_t               acc_eval;
  ncpl_pkg::eval_flags_t        flags;
  logic                         wr_valid;
  logic [ncpl_pkg::KEY_W-1:0]   wr_key;
  logic [ID_BITS-1:0]           wr_id;
  logic [ncpl_pkg::DIST_W-1:0]  wr_dist;

  logic in_beat;
  logic finish;
  logic issue;
  logic out_free;

  // Speed rule and result assembly
  logic [17:0]                   near_lim;
  logic [18:0]                   far_lim;
  logic [ncpl_pkg::MULT_W-1:0]   speed;
  logic [15:0]                   fin_new_id;
  logic                          fin_granted;
  logic [ncpl_pkg::MULT_W-1:0]   fin_mult;
  logic [ncpl_pkg::STATUS_W-1:0] fin_status;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  ncpl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  ncpl_slot_eval #(
    .ID_BITS (ID_BITS)
  ) u_eval (
    .func      (func_r),
    .key       (key_r),
    .lock_id   (lock_id_r),
    .distance  (dist_r),
    .next_id   (next_id_r),
    .ent_valid (ram_rdata[ENT_W-1]),
    .ent_key   (ram_rdata[KEY_LSB +: ncpl_pkg::KEY_W]),
    .ent_id    (ram_rdata[ID_LSB +: ID_BITS]),
    .ent_dist  (ram_rdata[ncpl_pkg::DIST_W-1:0]),
    .acc_in    (acc_r),
    .acc_out   (acc_eval),
    .flags     (flags),
    .wr_valid  (wr_valid),
    .wr_key    (wr_key),
    .wr_id     (wr_id),
    .wr_dist   (wr_dist)
  );

  // Scan ends on a hit or after the last slot
  assign finish = (state_r == ST_SCAN) && pend_r && (flags.hit || proc_idx_r == IDX_LAST);
  assign issue  = (state_r == ST_SCAN) && !finish && (cnt_r < CNT_END);
  assign ram_re = issue;

  // Write port: clearing pass or write-back of the evaluated slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = '0;
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (state_r == ST_SCAN && pend_r) begin
      ram_we    = flags.wr_en;
      ram_waddr = proc_idx_r;
      ram_wdata = {wr_valid, wr_key, wr_id, wr_dist};
    end
  end

  // Speed multiplier from distance against 3 and 6 radii
  assign near_lim = {2'b00, radius_r} + {1'b0, radius_r, 1'b0};
  assign far_lim  = {near_lim, 1'b0};
  always_comb begin
    if (dist_r <= ncpl_pkg::DIST_W'(near_lim)) begin
      speed = ncpl_pkg::MULT_BACK;
    end else if (dist_r < ncpl_pkg::DIST_W'(far_lim)) begin
      speed = ncpl_pkg::MULT_WAIT;
    end else begin
      speed = ncpl_pkg::MULT_GO;
    end
  end

  // Final result fields at the end of a scan
  always_comb begin
    fin_new_id  = '0;
    fin_granted = 1'b0;
    fin_mult    = ncpl_pkg::MULT_WAIT;
    fin_status  = ncpl_pkg::STATUS_OK;
    unique case (func_r)
      ncpl_pkg::FUNC_ACQUIRE: begin
        if (flags.hit) begin
          fin_new_id = 16'(next_id_r);
        end else begin
          fin_status = ncpl_pkg::STATUS_FULL;
        end
      end
      ncpl_pkg::FUNC_RELEASE: begin
        if (!flags.hit) begin
          fin_status = acc_eval.key_seen ? ncpl_pkg::STATUS_ID_ABSENT
                                         : ncpl_pkg::STATUS_KEY_ABSENT;
        end
      end
      ncpl_pkg::FUNC_QUERY: begin
        if (!acc_eval.key_seen) begin
          fin_mult   = speed;
          fin_status = ncpl_pkg::STATUS_KEY_ABSENT;
        end else begin
          fin_granted = acc_eval.have_best ? acc_eval.best_match : 1'b1;
          fin_mult    = fin_granted ? ncpl_pkg::MULT_GO : speed;
          fin_status  = acc_eval.id_seen ? ncpl_pkg::STATUS_OK
                                         : ncpl_pkg::STATUS_ID_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    next_id_nxt    = next_id_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    // Release the output register when the receiver takes the beat
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[IDX_W-1:0] == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          cnt_nxt   = '0;
          acc_nxt   = '{key_seen: 1'b0, id_seen: 1'b0, have_best: 1'b0,
                        best_match: 1'b0, best_dist: ncpl_pkg::DIST_UNSET};
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          acc_nxt = acc_eval;
        end
        if (issue) begin
          pend_nxt     = 1'b1;
          proc_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end
        if (finish) begin
          if (func_r == ncpl_pkg::FUNC_ACQUIRE && flags.hit) begin
            next_id_nxt = next_id_r + ID_BITS'(1);
          end
          res_nxt   = {3'b000, fin_status, fin_mult, fin_granted, fin_new_id};
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Move the result into the output register once it is free
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      next_id_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      next_id_r    <= next_id_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r    <= in_tuser;
      key_r     <= in_tdata[31:0];
      lock_id_r <= in_tdata[47:32];
      dist_r    <= in_tdata[71:48];
      radius_r  <= in_tdata[87:72];
    end
    proc_idx_r  <= proc_idx_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // The clearing pass writes an invalid slot every cycle
  a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (ram_we && !ram_wdata[ENT_W-1]))
    else $error("clearing pass did not invalidate a slot");

  // RAM writes only during clearing or on returned scan data
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_SCAN && pend_r)))
    else $error("RAM write outside clearing pass or scan write-back");

  // Returned read data is only pending inside a scan
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside a scan");

  // The id counter moves only on a successful acquire
  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(next_id_r) |->
      $past(finish && flags.hit && func_r == ncpl_pkg::FUNC_ACQUIRE))
    else $error("claim id advanced without a successful acquire");

endmodule

`default_nettype wire
